// ----- hdl/mcg_pkg.sv -----
// package: item types, constants and tables of the month calendar grid generator
package mcg_pkg;

    localparam int unsigned START_DAY       = 1;
    localparam int unsigned FEB_LEN_COMMON  = 28;
    localparam int unsigned LAST_YEAR       = 9999;
    localparam int unsigned WEEK_DAYS       = 7;
    localparam int unsigned RECIP_100       = 5243;
    localparam int unsigned RECIP_100_SHIFT = 19;
    localparam int unsigned RECIP_7         = 18725;
    localparam int unsigned RECIP_7_SHIFT   = 17;
    localparam int unsigned QUEUE_DEPTH     = 2;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
    } t_in_item;

    typedef struct packed {
        logic [4:0] day;
        logic [2:0] week_row;
        logic [2:0] weekday_col;
        logic       last_day;
    } t_out_item;

    typedef struct packed {
        logic [2:0] first_col;
        logic [4:0] len;
    } t_job;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_DIV,
        FS_SUM,
        FS_MOD,
        FS_PUSH
    } t_front_state;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] d;
        case (m)
            4'd1:    d = 5'd31;
            4'd2:    d = 5'(FEB_LEN_COMMON);
            4'd3:    d = 5'd31;
            4'd4:    d = 5'd30;
            4'd5:    d = 5'd31;
            4'd6:    d = 5'd30;
            4'd7:    d = 5'd31;
            4'd8:    d = 5'd31;
            4'd9:    d = 5'd30;
            4'd10:   d = 5'd31;
            4'd11:   d = 5'd30;
            4'd12:   d = 5'd31;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

    // (13 * m + 8) / 5 for shifted months 3..14
    function automatic logic [5:0] month_term(input logic [3:0] m);
        logic [5:0] t;
        case (m)
            4'd3:    t = 6'd9;
            4'd4:    t = 6'd12;
            4'd5:    t = 6'd14;
            4'd6:    t = 6'd17;
            4'd7:    t = 6'd19;
            4'd8:    t = 6'd22;
            4'd9:    t = 6'd25;
            4'd10:   t = 6'd27;
            4'd11:   t = 6'd30;
            4'd12:   t = 6'd32;
            4'd13:   t = 6'd35;
            4'd14:   t = 6'd38;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

// ----- hdl/mcg_front.sv -----
// front end: checks an item, finds weekday of the 1st and month length
module mcg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mcg_pkg::t_in_item i_item,
    output logic              o_stall,
    output logic              o_push,
    output mcg_pkg::t_job     o_job,
    input  logic              i_full
);

    localparam int unsigned RS = mcg_pkg::RECIP_100_SHIFT;
    localparam int unsigned SS = mcg_pkg::RECIP_7_SHIFT;

    mcg_pkg::t_front_state r_state, n_state;

    logic [13:0] r_y;
    logic [13:0] r_yy;
    logic [3:0]  r_mm;
    logic        r_feb;
    logic [4:0]  r_base_len;
    logic [6:0]  r_yq;
    logic [6:0]  r_q100;
    logic [13:0] r_sum;
    logic [4:0]  r_len;
    logic [10:0] r_q7;

    logic        w_in_ok;
    logic [26:0] w_prod_yy;
    logic [26:0] w_prod_y;
    logic [13:0] w_rem100;
    logic        w_leap;
    logic [13:0] w_sum;
    logic [28:0] w_prod7;
    logic [13:0] w_col;

    assign w_in_ok = (i_item.month >= 4'd1) && (i_item.month <= 4'd12) &&
                     (i_item.year >= 14'd1) && (i_item.year <= 14'(mcg_pkg::LAST_YEAR));

    assign w_prod_yy = 27'(r_yy) * 27'(mcg_pkg::RECIP_100);
    assign w_prod_y  = 27'(r_y) * 27'(mcg_pkg::RECIP_100);

    // year mod 100 from the quotient, leap rule on the real year
    assign w_rem100 = r_y - (14'(r_q100) * 14'd100);
    assign w_leap   = ((r_y[1:0] == 2'b00) && (w_rem100 != 14'd0)) ||
                      ((w_rem100 == 14'd0) && (r_q100[1:0] == 2'b00));

    assign w_sum = r_yy + {2'b00, r_yy[13:2]} - {7'd0, r_yq} + {9'd0, r_yq[6:2]}
                 + {8'd0, mcg_pkg::month_term(r_mm)} + 14'(mcg_pkg::START_DAY);

    assign w_prod7 = 29'(r_sum) * 29'(mcg_pkg::RECIP_7);
    assign w_col   = r_sum - ({r_q7, 3'b000} - {3'b000, r_q7});

    assign o_job.first_col = w_col[2:0];
    assign o_job.len       = r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcg_pkg::FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        o_push  = 1'b0;
        case (r_state)
            mcg_pkg::FS_IDLE: begin
                o_stall = 1'b0;
                if (i_valid && w_in_ok) begin
                    n_state = mcg_pkg::FS_DIV;
                end
            end
            mcg_pkg::FS_DIV: begin
                n_state = mcg_pkg::FS_SUM;
            end
            mcg_pkg::FS_SUM: begin
                n_state = mcg_pkg::FS_MOD;
            end
            mcg_pkg::FS_MOD: begin
                n_state = mcg_pkg::FS_PUSH;
            end
            mcg_pkg::FS_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = mcg_pkg::FS_IDLE;
                end
            end
            default: begin
                n_state = mcg_pkg::FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            mcg_pkg::FS_IDLE: begin
                r_y        <= i_item.year;
                r_feb      <= (i_item.month == 4'd2);
                r_base_len <= mcg_pkg::month_len(i_item.month);
                if (i_item.month < 4'd3) begin
                    r_yy <= 14'(i_item.year - 14'd1);
                    r_mm <= 4'(i_item.month + 4'd12);
                end else begin
                    r_yy <= i_item.year;
                    r_mm <= i_item.month;
                end
            end
            mcg_pkg::FS_DIV: begin
                r_yq   <= w_prod_yy[RS+6:RS];
                r_q100 <= w_prod_y[RS+6:RS];
            end
            mcg_pkg::FS_SUM: begin
                r_sum <= w_sum;
                r_len <= (r_feb && w_leap) ? 5'(mcg_pkg::FEB_LEN_COMMON + 1) : r_base_len;
            end
            mcg_pkg::FS_MOD: begin
                r_q7 <= w_prod7[SS+10:SS];
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- hdl/mcg_queue.sv -----
// short queue of month jobs between front and back
module mcg_queue #(
    parameter int unsigned DEPTH = mcg_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mcg_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output mcg_pkg::t_job o_job,
    output logic          o_nonempty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    mcg_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    logic w_do_push, w_do_pop;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_job      = r_mem[r_rd];
    assign w_do_push  = i_push && !o_full;
    assign w_do_pop   = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr + 1'b1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : PW'(r_rd + 1'b1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

endmodule

// ----- hdl/mcg_back.sv -----
// back end: walks the days of a month job and emits one item per day
module mcg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_nonempty,
    input  mcg_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_valid,
    output mcg_pkg::t_out_item o_item,
    input  logic               i_stall
);

    logic       r_active;
    logic [4:0] r_day;
    logic [2:0] r_row;
    logic [2:0] r_col;
    logic [4:0] r_len;
    logic       r_out_valid;
    mcg_pkg::t_out_item r_out;

    logic w_adv;
    logic w_last;

    assign o_pop   = !r_active && i_nonempty;
    assign w_adv   = r_active && (!r_out_valid || !i_stall);
    assign w_last  = (r_day == r_len);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active <= 1'b1;
            end else if (w_adv && w_last) begin
                r_active <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_day <= 5'(mcg_pkg::START_DAY);
            r_row <= 3'd0;
            r_col <= i_job.first_col;
            r_len <= i_job.len;
        end else if (w_adv) begin
            r_day <= 5'(r_day + 5'd1);
            if (r_col == 3'(mcg_pkg::WEEK_DAYS - 1)) begin
                r_col <= 3'd0;
                r_row <= 3'(r_row + 3'd1);
            end else begin
                r_col <= 3'(r_col + 3'd1);
            end
        end
        if (w_adv) begin
            r_out.day         <= r_day;
            r_out.week_row    <= r_row;
            r_out.weekday_col <= r_col;
            r_out.last_day    <= w_last;
        end
    end

endmodule

// ----- hdl/month_calendar_grid_generator.sv -----
// Month calendar grid generator: takes a Gregorian year and month and emits one
// item per day with its day number, grid row, weekday column (0 is Sunday) and a
// flag on the last day. An item with a year outside 1..9999 or a month outside
// 1..12 is taken and produces nothing. The front end takes a new item only when
// idle: its divide, sum and modulo states do the weekday and month length work
// through reciprocal multipliers, then it pushes into the job queue, waiting while
// the queue is full. The back end loads a job, then emits one day per cycle while
// the output is not stalled, so the day walker sets the sustained rate. The front
// end works on the next month while the back end is still emitting days.
module month_calendar_grid_generator #(
    parameter int unsigned QUEUE_DEPTH = mcg_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  mcg_pkg::t_in_item  i_item,
    output logic               o_stall,
    output logic               o_valid,
    output mcg_pkg::t_out_item o_item,
    input  logic               i_stall
);

    logic          w_push, w_full, w_pop, w_nonempty;
    mcg_pkg::t_job w_push_job, w_pop_job;

    mcg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .o_push  (w_push),
        .o_job   (w_push_job),
        .i_full  (w_full)
    );

    mcg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_job      (w_push_job),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_job      (w_pop_job),
        .o_nonempty (w_nonempty)
    );

    mcg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (w_nonempty),
        .i_job      (w_pop_job),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .o_item     (o_item),
        .i_stall    (i_stall)
    );

`ifndef SYNTHESIS
    a_stream_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_item.last_day) |=> o_valid)
        else $error("day stream broken before last day");

    a_day_increments: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_item.last_day) |=>
        (o_item.day == 5'($past(o_item.day) + 5'd1)))
        else $error("day number did not advance by one");

    a_grid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_item.weekday_col <= 3'd6) && (o_item.week_row <= 3'd5)))
        else $error("grid position out of range");

    a_first_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_item.last_day) |=>
        (!o_valid || ((o_item.day == 5'd1) && (o_item.week_row == 3'd0))))
        else $error("new month does not start at day one on row zero");
`endif

endmodule

// ----- test/mcg_checker.sv -----
// checker: predicts the day items of each accepted month and compares them with the block output
`timescale 1ns / 100ps

module mcg_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  mcg_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  mcg_pkg::t_out_item i_out_item,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int unsigned DAYS_PER_MONTH [12] = '{
        31, mcg_pkg::FEB_LEN_COMMON, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
    };

    mcg_pkg::t_out_item pending_cells[$];
    int                 mismatches = 0;

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    function automatic int unsigned days_of(input int unsigned y, input int unsigned m);
        int unsigned d;
        d = DAYS_PER_MONTH[m - 1];
        if (m == 2 && is_leap(y)) begin
            d = mcg_pkg::FEB_LEN_COMMON + 1;
        end
        return d;
    endfunction

    // january and february count as months 13 and 14 of the year before
    function automatic int unsigned first_weekday(input int unsigned y, input int unsigned m);
        int unsigned yy;
        int unsigned mm;
        yy = y;
        mm = m;
        if (mm < 3) begin
            yy = yy - 1;
            mm = mm + 12;
        end
        return (yy + yy / 4 - yy / 100 + yy / 400 + (13 * mm + 8) / 5 + mcg_pkg::START_DAY)
               % mcg_pkg::WEEK_DAYS;
    endfunction

    task automatic add_month_days(input mcg_pkg::t_in_item req);
        int unsigned        y;
        int unsigned        m;
        int unsigned        len;
        int unsigned        col;
        int unsigned        row;
        mcg_pkg::t_out_item exp_item;
        y = req.year;
        m = req.month;
        if (m < 1 || m > 12 || y < 1 || y > mcg_pkg::LAST_YEAR) begin
            return;
        end
        col = first_weekday(y, m);
        len = days_of(y, m);
        row = 0;
        for (int unsigned d = mcg_pkg::START_DAY; d <= len; d++) begin
            exp_item.day         = 5'(d);
            exp_item.week_row    = 3'(row);
            exp_item.weekday_col = 3'(col);
            exp_item.last_day    = (d == len);
            pending_cells.push_back(exp_item);
            col++;
            if (col >= mcg_pkg::WEEK_DAYS) begin
                col = 0;
                row++;
            end
        end
    endtask

    task automatic check_cell(input mcg_pkg::t_out_item got);
        mcg_pkg::t_out_item want;
        if (pending_cells.size() == 0) begin
            $error("unexpected item: day %0d row %0d col %0d last %0b",
                   got.day, got.week_row, got.weekday_col, got.last_day);
            mismatches++;
            return;
        end
        want = pending_cells.pop_front();
        if (got.day !== want.day) begin
            $error("day: expected %0d, got %0d", want.day, got.day);
            mismatches++;
        end
        if (got.week_row !== want.week_row) begin
            $error("week_row: expected %0d, got %0d", want.week_row, got.week_row);
            mismatches++;
        end
        if (got.weekday_col !== want.weekday_col) begin
            $error("weekday_col: expected %0d, got %0d", want.weekday_col, got.weekday_col);
            mismatches++;
        end
        if (got.last_day !== want.last_day) begin
            $error("last_day: expected %0b, got %0b", want.last_day, got.last_day);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                add_month_days(i_in_item);
            end
            if (i_out_valid && !i_out_stall) begin
                check_cell(i_out_item);
            end
        end
        o_errors  <= mismatches;
        o_pending <= pending_cells.size();
    end

endmodule

// ----- test/tb.sv -----
// testbench top: drives months into the calendar grid generator and gives the verdict
`timescale 1ns / 100ps

module tb;

    localparam int RESET_CYCLES = 9;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 287;
    localparam int HOLD_AT      = 1500;
    localparam int HOLD_LEN     = 600;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    mcg_pkg::t_in_item  in_item;
    logic               out_valid;
    logic               out_stall;
    mcg_pkg::t_out_item out_item;
    int                 errors;
    int                 pending;
    int                 quiet_cycles = 0;

    month_calendar_grid_generator u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .i_item  (in_item),
        .o_stall (in_stall),
        .o_valid (out_valid),
        .o_item  (out_item),
        .i_stall (out_stall)
    );

    mcg_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(15, 60);
    endfunction

    function automatic int pick_burst();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(100, 200);
        end
        return $urandom_range(1, 40);
    endfunction

    function automatic mcg_pkg::t_in_item ym(input int unsigned y, input int unsigned m);
        mcg_pkg::t_in_item req;
        req.year  = 14'(y);
        req.month = 4'(m);
        return req;
    endfunction

    function automatic mcg_pkg::t_in_item random_month();
        mcg_pkg::t_in_item req;
        int unsigned       pick;
        int unsigned       m;
        req.month = ($urandom_range(0, 9) < 3) ? 4'd2 : 4'($urandom_range(1, 12));
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            req.year = 14'($urandom_range(1, mcg_pkg::LAST_YEAR));
        end else if (pick < 60) begin
            req.year = 14'($urandom_range(1, 99) * 100);
        end else if (pick < 68) begin
            req.year = 14'($urandom_range(1, 24) * 400);
        end else if (pick < 80) begin
            req.year = 14'($urandom_range(1, 2499) * 4);
        end else if (pick < 88) begin
            req.year = $urandom_range(0, 1) ? 14'($urandom_range(1, 3))
                     : 14'($urandom_range(mcg_pkg::LAST_YEAR - 2, mcg_pkg::LAST_YEAR));
        end else if (pick < 94) begin
            m = $urandom_range(0, 3);
            req.month = (m == 0) ? 4'd0 : 4'(12 + m);
            req.year  = 14'($urandom_range(0, 16383));
        end else begin
            req.year = $urandom_range(0, 1) ? 14'd0
                     : 14'($urandom_range(mcg_pkg::LAST_YEAR + 1, 16383));
        end
        return req;
    endfunction

    task automatic send_month(input mcg_pkg::t_in_item req);
        int gap;
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (in_stall);
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // receiver: random stall runs, plus one long hold-off so the block backs up
    initial begin
        int   run;
        int   cyc;
        logic stalling;
        run      = 0;
        cyc      = 0;
        stalling = 1'b0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            cyc++;
            if (cyc == HOLD_AT) begin
                stalling = 1'b1;
                run      = HOLD_LEN;
            end else if (run <= 0) begin
                if (stalling) begin
                    stalling = 1'b0;
                    run      = pick_burst();
                end else begin
                    run = pick_gap();
                    if (run > 0) begin
                        stalling = 1'b1;
                    end else begin
                        run = pick_burst();
                    end
                end
            end
            out_stall <= stalling;
            run--;
        end
    end

    initial begin
        mcg_pkg::t_in_item directed[$];
        directed = '{
            ym(1, 1), ym(1, 2), ym(9999, 12), ym(9999, 2),
            ym(2000, 2), ym(1900, 2), ym(2024, 2), ym(2023, 2), ym(2100, 2), ym(1600, 2),
            ym(2023, 4), ym(2015, 3), ym(2015, 8), ym(2015, 11), ym(8191, 9),
            ym(2023, 0), ym(2023, 13), ym(2023, 15), ym(0, 5), ym(10000, 5),
            ym(16383, 15), ym(16383, 1), ym(2017, 12)
        };
        in_valid <= 1'b0;
        in_item  <= '0;
        rst_n    <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed[k]) begin
            send_month(directed[k]);
        end
        repeat (RANDOM_ITEMS) begin
            send_month(random_month());
        end
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
